FILE: design/html_entity_codec_top_macros.svh
// Assertion macros shared by the checker of html_entity_codec_top.
// Each macro expects i_clk and i_rst_n to be visible where it is used.
`ifndef HTML_ENTITY_CODEC_TOP_MACROS_SVH
`define HTML_ENTITY_CODEC_TOP_MACROS_SVH

// Same-cycle implication, checked only out of reset.
`define HEC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked only out of reset.
`define HEC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/hec_pkg.sv
// Package for the HTML entity codec: port payload types and the entity table.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package hec_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_text;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic       error;
    } t_out_item;

    localparam int ENT_NUM      = 6;
    localparam int ENT_NAME_MAX = 4;
    localparam int ENT_IDX_W    = 3;
    localparam int ENT_LEN_W    = 3;

    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_SEMI = 8'h3B;

    // Entity order: amp, nbsp, lt, gt, apos, quot.
    localparam logic [ENT_LEN_W-1:0] ENT_LEN [ENT_NUM] = '{
        3'd3, 3'd4, 3'd2, 3'd2, 3'd4, 3'd4
    };

    localparam logic [7:0] ENT_CH [ENT_NUM] = '{
        8'h26, 8'h20, 8'h3C, 8'h3E, 8'h27, 8'h22
    };

    localparam logic [7:0] ENT_NAME [ENT_NUM][ENT_NAME_MAX] = '{
        '{8'h61, 8'h6D, 8'h70, 8'h00},   // amp
        '{8'h6E, 8'h62, 8'h73, 8'h70},   // nbsp
        '{8'h6C, 8'h74, 8'h00, 8'h00},   // lt
        '{8'h67, 8'h74, 8'h00, 8'h00},   // gt
        '{8'h61, 8'h70, 8'h6F, 8'h73},   // apos
        '{8'h71, 8'h75, 8'h6F, 8'h74}    // quot
    };

endpackage

FILE: design/hec_queue.sv
// Two-entry request queue between the codec front and back ends.
// Depends on hec_pkg only by convention; payload is a flat vector.
`timescale 1ns / 1ps

module hec_queue
    import hec_pkg::*;
#(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data,
    input  logic             i_pop
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int FILL_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]  r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wptr;
    logic [PTR_W-1:0]  r_rptr;
    logic [FILL_W-1:0] r_fill;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_fill == FILL_W'(DEPTH));
    assign o_valid = (r_fill != '0);
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_fill <= '0;
        end else begin
            if (do_push) r_wptr <= r_wptr + PTR_W'(1);
            if (do_pop)  r_rptr <= r_rptr + PTR_W'(1);
            if (do_push && !do_pop)      r_fill <= r_fill + FILL_W'(1);
            else if (do_pop && !do_push) r_fill <= r_fill - FILL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wptr] <= i_data;
    end

endmodule

FILE: design/hec_front.sv
// Codec front end: accepts text bytes, holds the mode and the entity buffer,
// and turns each item into at most one output-run request. Uses hec_pkg.
`timescale 1ns / 1ps

module hec_front
    import hec_pkg::*;
#(
    parameter int MAX_ENTITY_LEN = 8,
    parameter int CMD_W = (MAX_ENTITY_LEN + 1) * 8 + $clog2(MAX_ENTITY_LEN + 2) + 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_wdata,
    input  logic             i_valid,
    input  t_in_item         i_item,
    output logic             o_stall,
    output logic             o_push,
    output logic [CMD_W-1:0] o_cmd,
    input  logic             i_full
);

    localparam int NB     = MAX_ENTITY_LEN + 1;
    localparam int IDX_W  = $clog2(NB);
    localparam int CNT_W  = $clog2(MAX_ENTITY_LEN + 2);
    localparam int ECNT_W = $clog2(MAX_ENTITY_LEN + 1);
    localparam int BUF_W  = $clog2(MAX_ENTITY_LEN);

    logic                                r_mode;
    logic [ECNT_W-1:0]                   r_ecnt;
    logic [MAX_ENTITY_LEN-1:0][7:0]      r_ebuf;
    logic [ECNT_W-1:0]                   n_ecnt;
    logic [MAX_ENTITY_LEN-1:0][7:0]      n_ebuf;

    logic [NB-1:0][7:0] c_bytes;
    logic [CNT_W-1:0]   c_cnt;
    logic               c_err;
    logic               accept;
    logic [7:0]         b;

    logic                 m_hit;
    logic                 m_ok;
    logic [7:0]           m_ch;
    logic                 e_hit;
    logic [ENT_IDX_W-1:0] e_idx;

    assign b       = i_item.in_byte;
    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;
    assign o_push  = accept && (c_cnt != '0);
    assign o_cmd   = {c_err, c_cnt, c_bytes};

    // Match buffered name (bytes after '&') against the entity table.
    always_comb begin
        m_hit = 1'b0;
        m_ch  = '0;
        m_ok  = 1'b0;
        for (int e = 0; e < ENT_NUM; e++) begin
            m_ok = (r_ecnt == ECNT_W'(ENT_LEN[e]) + ECNT_W'(1));
            for (int i = 0; i < ENT_NAME_MAX; i++) begin
                if ((ENT_LEN_W'(i) < ENT_LEN[e]) && (r_ebuf[i+1] != ENT_NAME[e][i]))
                    m_ok = 1'b0;
            end
            if (m_ok) begin
                m_hit = 1'b1;
                m_ch  = ENT_CH[e];
            end
        end
    end

    // Special characters for encode.
    always_comb begin
        e_hit = 1'b0;
        e_idx = '0;
        for (int e = 0; e < ENT_NUM; e++) begin
            if (b == ENT_CH[e]) begin
                e_hit = 1'b1;
                e_idx = ENT_IDX_W'(e);
            end
        end
    end

    always_comb begin
        n_ecnt  = r_ecnt;
        n_ebuf  = r_ebuf;
        c_bytes = '0;
        c_bytes[MAX_ENTITY_LEN-1:0] = r_ebuf;   // flush image by default
        c_cnt   = '0;
        c_err   = 1'b0;
        priority if (i_item.end_of_text) begin
            c_cnt  = CNT_W'(r_ecnt);
            n_ecnt = '0;
        end else if (!r_mode) begin
            if (e_hit) begin
                c_bytes[0] = CH_AMP;
                for (int j = 0; j < ENT_NAME_MAX; j++)
                    c_bytes[j+1] = ENT_NAME[e_idx][j];
                c_bytes[IDX_W'(ENT_LEN[e_idx]) + IDX_W'(1)] = CH_SEMI;
                c_cnt = CNT_W'(ENT_LEN[e_idx]) + CNT_W'(2);
            end else begin
                c_bytes[0] = b;
                c_cnt      = CNT_W'(1);
            end
        end else if (b == CH_AMP) begin
            // flush whatever was pending, then restart
            c_cnt     = CNT_W'(r_ecnt);
            n_ebuf[0] = CH_AMP;
            n_ecnt    = ECNT_W'(1);
        end else if (r_ecnt == '0) begin
            c_bytes[0] = b;
            c_cnt      = CNT_W'(1);
        end else if (b == CH_SEMI) begin
            n_ecnt = '0;
            c_cnt  = CNT_W'(1);
            if (m_hit) begin
                c_bytes[0] = m_ch;
            end else begin
                c_bytes[0] = '0;
                c_err      = 1'b1;
            end
        end else if (r_ecnt == ECNT_W'(MAX_ENTITY_LEN)) begin
            // overflow: buffer plus this byte go out literally
            c_bytes[MAX_ENTITY_LEN] = b;
            c_cnt  = CNT_W'(r_ecnt) + CNT_W'(1);
            n_ecnt = '0;
        end else begin
            n_ebuf[r_ecnt[BUF_W-1:0]] = b;
            n_ecnt = r_ecnt + ECNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_ecnt <= '0;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_wdata;
            r_ecnt <= '0;
        end else if (accept) begin
            r_ecnt <= n_ecnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) r_ebuf <= n_ebuf;
    end

endmodule

FILE: design/hec_back.sv
// Codec back end: plays out one request as a run of result bytes, one per
// cycle while not stalled, and holds the output register. Uses hec_pkg.
`timescale 1ns / 1ps

module hec_back
    import hec_pkg::*;
#(
    parameter int MAX_ENTITY_LEN = 8,
    parameter int CMD_W = (MAX_ENTITY_LEN + 1) * 8 + $clog2(MAX_ENTITY_LEN + 2) + 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  logic [CMD_W-1:0] i_q_data,
    output logic             o_q_pop,
    output logic             o_valid,
    output t_out_item        o_item,
    input  logic             i_stall
);

    localparam int NB    = MAX_ENTITY_LEN + 1;
    localparam int IDX_W = $clog2(NB);
    localparam int CNT_W = $clog2(MAX_ENTITY_LEN + 2);

    logic               r_busy;
    logic [IDX_W-1:0]   r_idx;
    logic [NB-1:0][7:0] r_bytes;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_err;
    logic               fire;
    logic               is_last;
    logic               load;

    assign fire    = r_busy && !i_stall;
    assign is_last = (CNT_W'(r_idx) + CNT_W'(1)) == r_cnt;
    assign load    = i_q_valid && (!r_busy || (fire && is_last));
    assign o_q_pop = load;

    assign o_valid         = r_busy;
    assign o_item.out_byte = r_bytes[r_idx];
    assign o_item.last     = is_last;
    assign o_item.error    = r_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (load) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (fire && is_last) begin
            r_busy <= 1'b0;
        end else if (fire) begin
            r_idx <= r_idx + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) {r_err, r_cnt, r_bytes} <= i_q_data;
    end

endmodule

FILE: design/html_entity_codec_top.sv
// HTML entity codec, top level. Each accepted text byte (or end-of-text mark)
// becomes a run of 0 to MAX_ENTITY_LEN+1 result bytes. In encode mode
// (decode_mode = 0) space, apostrophe, double quote, <, > and & expand to
// &nbsp; &apos; &quot; &lt; &gt; &amp; (4 to 6 results); other bytes pass
// through as one result. In decode mode text from '&' to ';' is held and a
// known name yields one character, an unknown one a single error result with
// a zero byte; a fresh '&', a buffer overflow or end-of-text flushes the held
// text literally. The last result of every run carries last = 1. Rate: the
// input side takes one item per cycle as long as the two-entry request queue
// has room, and the output side delivers one result per cycle unless stalled,
// so a stream that yields at most one result per item runs at one item per
// cycle, each request passing the queue and the back-end register before its
// first result; an item that yields n results holds the back end until all n
// are out, and the queue lets two more items be taken meanwhile. Write
// decode_mode only while the block is idle; a write drops any held entity text.
// Depends on hec_pkg, hec_front, hec_queue and hec_back.
`timescale 1ns / 1ps

module html_entity_codec_top
    import hec_pkg::*;
#(
    parameter int MAX_ENTITY_LEN = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    // configuration: decode_mode
    input  logic      i_cfg_we,
    input  logic      i_cfg_wdata,
    // input requests
    input  logic      i_in_valid,
    input  t_in_item  i_in_data,
    output logic      o_in_stall,
    // result requests
    output logic      o_out_valid,
    output t_out_item o_out_data,
    input  logic      i_out_stall
);

    // Request word: {error flag, byte count, bytes[MAX_ENTITY_LEN:0]}
    localparam int CMD_W = (MAX_ENTITY_LEN + 1) * 8 + $clog2(MAX_ENTITY_LEN + 2) + 1;

    logic             f_push;
    logic [CMD_W-1:0] f_cmd;
    logic             q_full;
    logic             q_valid;
    logic [CMD_W-1:0] q_data;
    logic             q_pop;

    // Front: classifies each byte and keeps the entity buffer.
    hec_front #(
        .MAX_ENTITY_LEN (MAX_ENTITY_LEN),
        .CMD_W          (CMD_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_in_valid),
        .i_item      (i_in_data),
        .o_stall     (o_in_stall),
        .o_push      (f_push),
        .o_cmd       (f_cmd),
        .i_full      (q_full)
    );

    // Queue decouples a long expansion or flush from the input side.
    hec_queue #(
        .WIDTH (CMD_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  (f_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_data),
        .i_pop   (q_pop)
    );

    // Back: emits the bytes of each request, one per result handshake.
    hec_back #(
        .MAX_ENTITY_LEN (MAX_ENTITY_LEN),
        .CMD_W          (CMD_W)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_data),
        .o_q_pop   (q_pop),
        .o_valid   (o_out_valid),
        .o_item    (o_out_data),
        .i_stall   (i_out_stall)
    );

endmodule

FILE: design/hec_checker.sv
// Port-level checker for html_entity_codec_top, bound to the top level.
// Uses hec_pkg and the macros in html_entity_codec_top_macros.svh.
`timescale 1ns / 1ps
`include "html_entity_codec_top_macros.svh"

module hec_checker
    import hec_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input t_out_item o_out_data,
    input logic      i_out_stall
);

    // a stalled result holds
    `HEC_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data), "stalled result changed")

    // an error result ends its run
    `HEC_ASSERT_NOW(a_err_last, o_out_valid && o_out_data.error, o_out_data.last, "error result not last")

    `HEC_ASSERT_NOW(a_err_zero, o_out_valid && o_out_data.error, o_out_data.out_byte == 8'h00, "error result with nonzero byte")

    // the back end comes out of reset idle and the queue not full
    `HEC_ASSERT_NOW(a_rst_empty, $past(!i_rst_n), !o_out_valid && !o_in_stall, "not empty after reset")

endmodule

bind html_entity_codec_top hec_checker u_hec_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out_data  (o_out_data),
    .i_out_stall (i_out_stall)
);

FILE: tb/hec_result_check.sv
// Result checker for html_entity_codec_top: mirrors the codec on every accepted
// request and compares the delivered result bytes in order, field by field.
// Depends on hec_pkg for the request and result payload types.
`timescale 1ns / 1ps

module hec_result_check
    import hec_pkg::*;
#(
    parameter int MAX_ENTITY_LEN = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic      i_cfg_wdata,
    input  logic      i_in_valid,
    input  t_in_item  i_in_data,
    input  logic      i_in_stall,
    input  logic      i_out_valid,
    input  t_out_item i_out_data,
    input  logic      i_out_stall,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_checked
);

    localparam int         NUM_NAMES  = 6;
    localparam logic [7:0] AMP_CHAR   = 8'h26;
    localparam logic [7:0] SEMI_CHAR  = 8'h3B;

    t_out_item  pending_bytes[$];
    logic       mode_dec;
    logic [7:0] held [MAX_ENTITY_LEN];
    int         held_cnt;
    int         fails;
    int         checked;

    function automatic string entity_name(int e);
        case (e)
            0:       return "amp";
            1:       return "nbsp";
            2:       return "lt";
            3:       return "gt";
            4:       return "apos";
            default: return "quot";
        endcase
    endfunction

    function automatic logic [7:0] entity_char(int e);
        case (e)
            0:       return 8'h26;
            1:       return 8'h20;
            2:       return 8'h3C;
            3:       return 8'h3E;
            4:       return 8'h27;
            default: return 8'h22;
        endcase
    endfunction

    function automatic void push_byte(logic [7:0] b, logic err);
        t_out_item r;
        r.out_byte = b;
        r.last     = 1'b0;
        r.error    = err;
        pending_bytes.push_back(r);
    endfunction

    // held text goes out literally
    function automatic void flush_held();
        for (int i = 0; i < held_cnt; i++)
            push_byte(held[i], 1'b0);
        held_cnt = 0;
    endfunction

    // index of the entity named by held[1 .. held_cnt-1], -1 if none
    function automatic int lookup_entity();
        string nm;
        int    ok;
        for (int e = 0; e < NUM_NAMES; e++) begin
            nm = entity_name(e);
            if (nm.len() == held_cnt - 1) begin
                ok = 1;
                for (int i = 0; i < nm.len(); i++)
                    if (held[i + 1] != 8'(nm[i]))
                        ok = 0;
                if (ok != 0)
                    return e;
            end
        end
        return -1;
    endfunction

    function automatic void encode_byte(logic [7:0] b);
        string nm;
        for (int e = 0; e < NUM_NAMES; e++) begin
            if (entity_char(e) == b) begin
                nm = entity_name(e);
                push_byte(AMP_CHAR, 1'b0);
                for (int i = 0; i < nm.len(); i++)
                    push_byte(8'(nm[i]), 1'b0);
                push_byte(SEMI_CHAR, 1'b0);
                return;
            end
        end
        push_byte(b, 1'b0);
    endfunction

    function automatic void decode_byte(logic [7:0] b);
        int e;
        if (b == AMP_CHAR) begin
            flush_held();
            held[0]  = AMP_CHAR;
            held_cnt = 1;
        end else if (held_cnt == 0) begin
            push_byte(b, 1'b0);
        end else if (b == SEMI_CHAR) begin
            e        = lookup_entity();
            held_cnt = 0;
            if (e < 0)
                push_byte(8'h00, 1'b1);
            else
                push_byte(entity_char(e), 1'b0);
        end else if (held_cnt >= MAX_ENTITY_LEN) begin
            flush_held();
            push_byte(b, 1'b0);
        end else begin
            held[held_cnt] = b;
            held_cnt++;
        end
    endfunction

    // results of one request are appended; the final one gets last set
    function automatic void convert_request(t_in_item req);
        int        base;
        t_out_item tail;
        base = pending_bytes.size();
        if (req.end_of_text)
            flush_held();
        else if (mode_dec)
            decode_byte(req.in_byte);
        else
            encode_byte(req.in_byte);
        if (pending_bytes.size() > base) begin
            tail      = pending_bytes[pending_bytes.size() - 1];
            tail.last = 1'b1;
            pending_bytes[pending_bytes.size() - 1] = tail;
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_out_item want;
        if (!i_rst_n) begin
            mode_dec = 1'b0;
            held_cnt = 0;
            fails    = 0;
            checked  = 0;
            pending_bytes.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (pending_bytes.size() == 0) begin
                    fails++;
                    $display("%0t: extra result, expected none, got byte %02h last %b error %b",
                             $time, i_out_data.out_byte, i_out_data.last, i_out_data.error);
                end else begin
                    want = pending_bytes.pop_front();
                    checked++;
                    if (i_out_data.out_byte !== want.out_byte ||
                        i_out_data.last     !== want.last ||
                        i_out_data.error    !== want.error) begin
                        fails++;
                        $display("%0t: mismatch, expected byte %02h last %b error %b,",
                                 $time, want.out_byte, want.last, want.error,
                                 " got byte %02h last %b error %b",
                                 i_out_data.out_byte, i_out_data.last, i_out_data.error);
                    end
                end
            end
            if (i_cfg_we) begin
                mode_dec = i_cfg_wdata;
                held_cnt = 0;
            end
            if (i_in_valid && !i_in_stall)
                convert_request(i_in_data);
        end
        o_fail_count <= fails;
        o_pending    <= pending_bytes.size();
        o_checked    <= checked;
    end

endmodule

FILE: tb/tb_html_entity_codec_top.sv
// Testbench top for html_entity_codec_top: drives requests and mode writes,
// randomizes idling on both channels and reports the verdict.
// Depends on hec_pkg, the codec RTL and hec_result_check.
`timescale 1ns / 1ps

module tb_html_entity_codec_top;
    import hec_pkg::*;

    localparam int         MAX_ENTITY_LEN = 8;
    // no handshake of any kind for this many cycles means the block hung
    localparam int         IDLE_LIMIT     = 2000;
    // extra wait after every predicted result has drained, before a mode write
    localparam int         SETTLE_CYCLES  = 8;
    localparam int         TAIL_CYCLES    = 20;
    localparam logic [7:0] AMP_CHAR       = 8'h26;
    localparam logic [7:0] SEMI_CHAR      = 8'h3B;
    localparam logic       MODE_ENCODE    = 1'b0;
    localparam logic       MODE_DECODE    = 1'b1;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      cfg_we;
    logic      cfg_wdata;
    logic      in_valid;
    t_in_item  in_data;
    logic      in_stall;
    logic      out_valid;
    t_out_item out_data;
    logic      out_stall;

    int        fail_count;
    int        pending;
    int        checked;

    // stimulus bookkeeping
    logic      decode_on;
    logic      calm;          // when set neither side idles
    int        sent;
    int        sent_decode;
    int        writes;
    int        stall_left;
    int        idle_cycles;

    always #5 clk = ~clk;

    html_entity_codec_top #(
        .MAX_ENTITY_LEN(MAX_ENTITY_LEN)
    ) uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_data),
        .i_out_stall (out_stall)
    );

    hec_result_check #(
        .MAX_ENTITY_LEN(MAX_ENTITY_LEN)
    ) u_result_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_in_valid   (in_valid),
        .i_in_data    (in_data),
        .i_in_stall   (in_stall),
        .i_out_valid  (out_valid),
        .i_out_data   (out_data),
        .i_out_stall  (out_stall),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // Idle length for one request or one result: zero half the time,
    // otherwise a random draw, zero included. Calm stretches never idle.
    function automatic int draw_wait();
        if (calm || $urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(0, 11);
    endfunction

    // The six bytes that encode into entities.
    function automatic logic [7:0] special_char(int e);
        case (e)
            0:       return 8'h20;
            1:       return 8'h27;
            2:       return 8'h22;
            3:       return 8'h3C;
            4:       return 8'h3E;
            default: return 8'h26;
        endcase
    endfunction

    function automatic string known_name(int e);
        case (e)
            0:       return "amp";
            1:       return "nbsp";
            2:       return "lt";
            3:       return "gt";
            4:       return "apos";
            default: return "quot";
        endcase
    endfunction

    // Byte inside an entity body: never '&' or ';'. Lowercase half the time
    // so that bodies now and then collide with a real name.
    function automatic logic [7:0] body_char();
        logic [7:0] b;
        if ($urandom_range(0, 1) == 0)
            return 8'($urandom_range(8'h61, 8'h7A));
        b = 8'($urandom_range(0, 255));
        while (b == AMP_CHAR || b == SEMI_CHAR)
            b = 8'($urandom_range(0, 255));
        return b;
    endfunction

    // Result side: after each accepted result, stall for a drawn number
    // of cycles, then hold stall low until the next result is taken.
    always @(posedge clk) begin : result_pacing
        int n;
        if (!rst_n) begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end else if (out_valid && !out_stall) begin
            n = draw_wait();
            stall_left <= n;
            out_stall  <= (n > 0);
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_stall  <= (stall_left > 1);
        end
    end

    // Watchdog: any accepted request, result or mode write restarts the count.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no handshake for %0d cycles, giving up", $time, IDLE_LIMIT);
                $display("status: fail");
                $finish;
            end
        end
    end

    // Presents one request after a drawn gap and returns at the edge that
    // takes it. With no gap, valid stays high and only the payload moves on.
    task automatic send_request(input logic [7:0] b, input logic eot);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid                <= 1'b1;
        in_data.in_byte         <= b;
        in_data.end_of_text     <= eot;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sent++;
        if (decode_on)
            sent_decode++;
    endtask

    // Mode writes only happen with the block idle: every predicted result
    // has drained, and the SETTLE_CYCLES margin passes on top of that.
    task automatic drain_and_set_mode(input logic m);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we    <= 1'b0;
        decode_on = m;
        writes++;
    endtask

    // Encode traffic: a quarter special bytes, the rest anything, and an
    // occasional end-of-text mark (which yields nothing in this mode).
    task automatic random_encode_phase(input int count);
        logic [7:0] b;
        for (int k = 0; k < count; k++) begin
            if (k % 16 == 0)
                calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 3) == 0)
                b = special_char($urandom_range(0, 5));
            else
                b = 8'($urandom_range(0, 255));
            send_request(b, $urandom_range(0, 15) == 0);
        end
    endtask

    // Decode traffic is built from whole entity shapes with random bodies
    // so that the buffer really fills; noise and plain text are mixed in.
    task automatic random_decode_phase(input int count);
        int    start;
        int    len;
        string nm;
        start = sent;
        while (sent - start < count) begin
            if ($urandom_range(0, 7) == 0)
                calm = !calm;
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    // well-formed known entity
                    nm = known_name($urandom_range(0, 5));
                    send_request(AMP_CHAR, 1'b0);
                    for (int i = 0; i < nm.len(); i++)
                        send_request(8'(nm[i]), 1'b0);
                    send_request(SEMI_CHAR, 1'b0);
                end
                3: begin
                    // terminated body of any length, empty included
                    len = $urandom_range(0, MAX_ENTITY_LEN - 1);
                    send_request(AMP_CHAR, 1'b0);
                    repeat (len) send_request(body_char(), 1'b0);
                    send_request(SEMI_CHAR, 1'b0);
                end
                4: begin
                    // semicolon arriving on a full buffer
                    send_request(AMP_CHAR, 1'b0);
                    repeat (MAX_ENTITY_LEN - 1) send_request(body_char(), 1'b0);
                    send_request(SEMI_CHAR, 1'b0);
                end
                5: begin
                    // overflow, sometimes followed by more loose text
                    len = $urandom_range(0, 2);
                    send_request(AMP_CHAR, 1'b0);
                    repeat (MAX_ENTITY_LEN + len) send_request(body_char(), 1'b0);
                end
                6: begin
                    // unterminated: whatever comes next decides its fate
                    len = $urandom_range(0, 5);
                    send_request(AMP_CHAR, 1'b0);
                    repeat (len) send_request(body_char(), 1'b0);
                end
                7: begin
                    // end of text while buffering
                    len = $urandom_range(0, MAX_ENTITY_LEN - 1);
                    send_request(AMP_CHAR, 1'b0);
                    repeat (len) send_request(body_char(), 1'b0);
                    send_request(8'($urandom_range(0, 255)), 1'b1);
                end
                8: begin
                    // raw noise, any byte and the odd end-of-text
                    len = $urandom_range(1, 4);
                    repeat (len)
                        send_request(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
                end
                default: begin
                    len = $urandom_range(1, 4);
                    repeat (len) send_request(body_char(), 1'b0);
                end
            endcase
        end
    endtask

    initial begin
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_wdata   = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        decode_on   = 1'b0;
        calm        = 1'b0;
        sent        = 0;
        sent_decode = 0;
        writes      = 0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed encode: value extremes, all six specials, end of text.
        drain_and_set_mode(MODE_ENCODE);
        send_request(8'h00, 1'b0);
        send_request(8'hFF, 1'b0);
        for (int e = 0; e < 6; e++)
            send_request(special_char(e), 1'b0);
        send_request(8'hA5, 1'b1);

        // Directed decode: zero byte, end of text with nothing held, a new
        // ampersand flushing "&x", a known entity, end of text flushing "&ab",
        // and finally "&q" left held so the next mode write must drop it.
        drain_and_set_mode(MODE_DECODE);
        send_request(8'h00, 1'b0);
        send_request(8'h5A, 1'b1);
        send_request(AMP_CHAR, 1'b0);
        send_request(8'h78, 1'b0);
        send_request(AMP_CHAR, 1'b0);
        send_request(8'h67, 1'b0);
        send_request(8'h74, 1'b0);
        send_request(SEMI_CHAR, 1'b0);
        send_request(AMP_CHAR, 1'b0);
        send_request(8'h61, 1'b0);
        send_request(8'h62, 1'b0);
        send_request(8'h00, 1'b1);
        send_request(AMP_CHAR, 1'b0);
        send_request(8'h71, 1'b0);

        // Random part, switching modes between phases.
        drain_and_set_mode(MODE_ENCODE);
        random_encode_phase(40);
        drain_and_set_mode(MODE_DECODE);
        random_decode_phase(80);
        drain_and_set_mode(MODE_ENCODE);
        random_encode_phase(25);
        drain_and_set_mode(MODE_DECODE);
        random_decode_phase(35);

        // Let every predicted result arrive, then watch a while for strays.
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d requests (%0d while decoding) across %0d mode writes",
                 sent, sent_decode, writes);
        $display("%0d results compared, %0d failures", checked, fail_count);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+design
design/hec_pkg.sv
design/hec_queue.sv
design/hec_front.sv
design/hec_back.sv
design/html_entity_codec_top.sv
design/hec_checker.sv
tb/hec_result_check.sv
tb/tb_html_entity_codec_top.sv
